// ----- rtl/core/scm_pkg.sv -----
// Shared constants, codes and types of the serial command matcher.
package scm_pkg;

	localparam int COMMAND_SLOTS = 8;
	localparam int NAME_LENGTH   = 16;
	localparam int LINE_CAPACITY = 64;

	localparam int SLOT_W  = $clog2(COMMAND_SLOTS);
	localparam int POS_W   = $clog2(NAME_LENGTH);
	localparam int LEN_W   = $clog2(LINE_CAPACITY);
	localparam int COUNT_W = 4;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [2:0] load_slot;
		logic [3:0] load_position;
	} item_t;

	typedef struct packed {
		logic       command_found;
		logic [2:0] command_index;
	} result_t;

	typedef logic [COMMAND_SLOTS-1:0][7:0] name_row_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [7:0]        data;
	} table_wr_t;

	typedef struct packed {
		logic              line_end;
		logic              found;
		logic [SLOT_W-1:0] index;
	} match_res_t;

endpackage

// ----- rtl/core/scm_name_table.sv -----
// Command name storage, one row per character position holding that byte of every slot.
module scm_name_table
	import scm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  table_wr_t        wr,
	input  logic [POS_W-1:0] rd_pos,
	output name_row_t        rd_row
);

	name_row_t rows_q [NAME_LENGTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NAME_LENGTH; p++) begin
				rows_q[p] <= '0;
			end
		end else if (wr.en) begin
			rows_q[wr.pos][wr.slot] <= wr.data;
		end
	end

	assign rd_row = rows_q[rd_pos];

endmodule

// ----- rtl/core/scm_match.sv -----
// Line state and per-slot match mask, with the line-end decision.
module scm_match
	import scm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         char_byte,
	input  logic [COUNT_W-1:0] command_count,
	input  name_row_t          row,
	output logic [POS_W-1:0]   rd_pos,
	output match_res_t         res
);

	logic [COMMAND_SLOTS-1:0] alive_q;
	logic [LEN_W-1:0]         length_q;
	logic                     nul_q;

	logic                     is_end;
	logic                     compare_on;
	logic                     line_full;
	logic [COMMAND_SLOTS-1:0] eq_mask;
	logic [COMMAND_SLOTS-1:0] zero_mask;
	logic [COMMAND_SLOTS-1:0] hit_mask;

	assign is_end     = (char_byte == CHAR_LF) || (char_byte == CHAR_CR);
	assign compare_on = !nul_q && ({1'b0, length_q} < (LEN_W+1)'(NAME_LENGTH));
	assign line_full  = length_q >= LEN_W'(LINE_CAPACITY - 1);
	assign rd_pos     = length_q[POS_W-1:0];

	always_comb begin
		for (int s = 0; s < COMMAND_SLOTS; s++) begin
			eq_mask[s]   = row[s] == char_byte;
			zero_mask[s] = row[s] == CHAR_NUL;
			hit_mask[s]  = alive_q[s] && (!compare_on || zero_mask[s]) &&
				(command_count > COUNT_W'(s));
		end
	end

	always_comb begin
		res.line_end = is_end;
		res.found    = |hit_mask;
		res.index    = '0;
		for (int s = COMMAND_SLOTS - 1; s >= 0; s--) begin
			if (hit_mask[s]) begin
				res.index = SLOT_W'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q  <= '1;
			length_q <= '0;
			nul_q    <= 1'b0;
		end else if (step) begin
			if (is_end) begin
				alive_q  <= '1;
				length_q <= '0;
				nul_q    <= 1'b0;
			end else if (!line_full) begin
				if (compare_on) begin
					alive_q <= alive_q & eq_mask;
					if (char_byte == CHAR_NUL) begin
						nul_q <= 1'b1;
					end
				end
				length_q <= length_q + LEN_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/serial_command_matcher.sv -----
// Top level of the serial command matcher: input register, match stage and result register.
//
//   channel  signals                          direction  content
//   item     item_valid, item_stall, item     in         character or name byte load
//   result   result_valid, result_stall, result  out    found flag and lowest slot
//   cfg      cfg_valid, cfg_ready, cfg_data   in         command_count
//
// One item is taken every cycle while item_stall is low; a line end's result passes the input and result registers.
// The name table compare and the match state update happen between the input register and the result register.
// Reset clears the name table, the line state, command_count and both valid flags.
// A stalled result holds the match stage; item_stall rises only while a result waits.
module serial_command_matcher
	import scm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	logic               valid_s1;
	item_t              item_s1;
	logic [COUNT_W-1:0] count_q;
	result_t            result_q;
	logic               result_valid_q;

	logic               advance;
	logic               step;
	logic               char_step;
	table_wr_t          tbl_wr;
	logic [POS_W-1:0]   rd_pos;
	name_row_t          rd_row;
	match_res_t         mres;

	assign advance    = !result_valid_q || !result_stall;
	assign step       = valid_s1 && advance;
	assign char_step  = step && (item_s1.kind == KIND_CHAR);
	assign item_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	assign tbl_wr.en   = step && (item_s1.kind == KIND_LOAD);
	assign tbl_wr.slot = SLOT_W'(item_s1.load_slot);
	assign tbl_wr.pos  = POS_W'(item_s1.load_position);
	assign tbl_wr.data = item_s1.data_byte;

	scm_name_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.rd_pos (rd_pos),
		.rd_row (rd_row)
	);

	scm_match u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (char_step),
		.char_byte     (item_s1.data_byte),
		.command_count (count_q),
		.row           (rd_row),
		.rd_pos        (rd_pos),
		.res           (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			count_q        <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= char_step && mres.line_end;
			end
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance && char_step && mres.line_end) begin
			result_q.command_found <= mres.found;
			result_q.command_index <= 3'(mres.index);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/core/scm_checker.sv -----
// Port-level checks of the serial command matcher and their binding to the top level.
module scm_checker
	import scm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input result_t            result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result changed or vanished.");

	a_no_match_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.command_found |-> result.command_index == 3'd0)
		else $error("Index is not zero on a result without a match.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("Input stalled while no result was held back.");

	a_drop_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("Result valid dropped without a transfer.");

endmodule

bind serial_command_matcher scm_checker u_scm_checker (.*);

// ----- tb/serial_command_matcher_tb.sv -----
// Self-checking testbench of the serial command matcher with a line-matching scoreboard.
module serial_command_matcher_tb;
	import scm_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int PHASES        = 12;

	class match_scoreboard;
		logic [7:0] names [COMMAND_SLOTS][NAME_LENGTH];
		logic [COMMAND_SLOTS-1:0] alive;
		int unsigned line_len;
		bit nul_seen;
		logic [COUNT_W-1:0] count;
		result_t expected_q [$];
		int errors;
		int lines;
		int matched;
		int effective;

		function new();
			foreach (names[s, p]) names[s][p] = CHAR_NUL;
			count = '0;
			errors = 0;
			lines = 0;
			matched = 0;
			effective = 0;
			clear_line();
		endfunction

		function void clear_line();
			alive = '1;
			line_len = 0;
			nul_seen = 1'b0;
		endfunction

		function void set_count(logic [COUNT_W-1:0] value);
			count = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(item_t it);
			logic [COMMAND_SLOTS-1:0] mask;
			int active;
			result_t r;
			if (it.kind == KIND_LOAD) begin
				names[it.load_slot][it.load_position] = it.data_byte;
				effective++;
			end else if (it.data_byte == CHAR_LF || it.data_byte == CHAR_CR) begin
				mask = alive;
				if (!nul_seen && line_len < NAME_LENGTH) begin
					for (int s = 0; s < COMMAND_SLOTS; s++) begin
						if (names[s][line_len] != CHAR_NUL) mask[s] = 1'b0;
					end
				end
				active = (count < COMMAND_SLOTS) ? int'(count) : COMMAND_SLOTS;
				r = '0;
				for (int s = active - 1; s >= 0; s--) begin
					if (mask[s]) begin
						r.command_found = 1'b1;
						r.command_index = 3'(s);
					end
				end
				expected_q.push_back(r);
				lines++;
				if (r.command_found) matched++;
				effective++;
				clear_line();
			end else if (line_len < LINE_CAPACITY - 1) begin
				if (!nul_seen && line_len < NAME_LENGTH) begin
					for (int s = 0; s < COMMAND_SLOTS; s++) begin
						if (names[s][line_len] != it.data_byte) alive[s] = 1'b0;
					end
					if (it.data_byte == CHAR_NUL) nul_seen = 1'b1;
				end
				line_len++;
				effective++;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result found=%0b index=%0d with no line end pending",
					got.command_found, got.command_index));
			end else begin
				want = expected_q.pop_front();
				if (got.command_found !== want.command_found)
					report($sformatf("command_found %0b, expected %0b",
						got.command_found, want.command_found));
				if (got.command_index !== want.command_index)
					report($sformatf("command_index %0d, expected %0d",
						got.command_index, want.command_index));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	match_scoreboard sb;
	bit quiet;
	int config_writes;
	int stall_left;
	int idle_cycles;
	int phase_counts [PHASES] = '{15, 3, 0, 8, 1, 5, 9, 7, 2, 8, 6, 4};

	serial_command_matcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function logic [7:0] rand_noise();
		logic [7:0] c;
		do c = 8'($urandom); while (c == CHAR_LF || c == CHAR_CR);
		return c;
	endfunction

	function logic [7:0] rand_text();
		if ($urandom_range(0, 9) != 0) return 8'h61 + 8'($urandom_range(0, 3));
		return rand_noise();
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) sb.check_result(result);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				stall_left = gap_len();
				if (stall_left > 0) begin
					stall_left--;
					result_stall <= 1'b1;
				end else begin
					result_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task send_item(item_t it);
		int gap;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		gap = gap_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task send_char(logic [7:0] c);
		item_t it;
		it.kind = KIND_CHAR;
		it.data_byte = c;
		it.load_slot = 3'($urandom);
		it.load_position = 4'($urandom);
		send_item(it);
	endtask

	task send_load(int slot, int pos, logic [7:0] b);
		item_t it;
		it.kind = KIND_LOAD;
		it.data_byte = b;
		it.load_slot = 3'(slot);
		it.load_position = 4'(pos);
		send_item(it);
	endtask

	task load_random();
		send_load($urandom_range(0, COMMAND_SLOTS - 1), $urandom_range(0, NAME_LENGTH - 1),
			8'($urandom));
	endtask

	task load_name(int slot);
		int len;
		len = ($urandom_range(0, 99) < 10) ? NAME_LENGTH : $urandom_range(0, 6);
		for (int p = 0; p < len; p++) send_load(slot, p, rand_text());
		if (len < NAME_LENGTH) send_load(slot, len, CHAR_NUL);
	endtask

	task type_line();
		int slot;
		int len;
		int cut;
		int mode;
		logic [7:0] c;
		slot = $urandom_range(0, COMMAND_SLOTS - 1);
		mode = $urandom_range(0, 99);
		if (mode < 70) begin
			len = 0;
			while (len < NAME_LENGTH && sb.names[slot][len] != CHAR_NUL) len++;
			cut = (mode < 35) ? len : $urandom_range(0, len);
			for (int p = 0; p < cut; p++) begin
				c = sb.names[slot][p];
				if (mode >= 55 && p == cut - 1) c = rand_text();
				send_char(c);
				if ($urandom_range(0, 99) < 3) load_random();
			end
			if (mode >= 35 && mode < 45) begin
				send_char(CHAR_NUL);
				repeat ($urandom_range(0, 4)) send_char(rand_text());
			end else if (mode >= 45 && mode < 55) begin
				repeat ($urandom_range(1, 6)) send_char(rand_text());
			end
		end else if (mode < 80) begin
			repeat ($urandom_range(1, 8)) send_char(rand_text());
		end else if (mode >= 88 && mode < 94) begin
			repeat ($urandom_range(50, 80)) send_char(rand_text());
		end else if (mode >= 94) begin
			repeat ($urandom_range(1, 10)) send_char(rand_noise());
		end
		send_char($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
	endtask

	task drain_results();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_count(logic [COUNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_count(value);
		config_writes++;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int target;
		int r;
		sb = new();
		quiet = 1'b1;
		config_writes = 0;
		stall_left = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_count(COUNT_W'(COMMAND_SLOTS));

		send_char(CHAR_CR);
		send_load(7, 0, 8'h61);
		send_load(7, 1, 8'h62);
		send_char(8'h61);
		send_char(8'h62);
		send_char(CHAR_LF);
		send_load(7, NAME_LENGTH - 1, 8'hFF);
		send_char(CHAR_NUL);
		send_char(8'h78);
		send_char(CHAR_LF);
		send_char(8'hFF);
		send_char(CHAR_CR);
		send_load(0, 0, 8'h61);
		send_char(8'h61);
		send_char(CHAR_CR);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_count(COUNT_W'(phase_counts[ph]));
			quiet = (ph % 4 == 1);
			target = sb.effective + RANDOM_ITEMS / PHASES;
			while (sb.effective < target) begin
				r = $urandom_range(0, 99);
				if (r < 10) load_name($urandom_range(0, COMMAND_SLOTS - 1));
				else if (r < 14) load_random();
				else if (r == 14) drain_results();
				else type_line();
			end
		end
		drain_results();

		$display("Ran %0d items and checked %0d line ends, %0d of them matching a name.",
			sb.effective, sb.lines, sb.matched);
		$display("The command count took %0d settings, from none to beyond the table.",
			config_writes);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- serial_command_matcher.f -----
rtl/core/scm_pkg.sv
rtl/core/scm_name_table.sv
rtl/core/scm_match.sv
rtl/core/serial_command_matcher.sv
rtl/core/scm_checker.sv
tb/serial_command_matcher_tb.sv
